### hw/rtl/bns_pkg.sv
// Shared types, codes and note tables for the buzzer note sequencer.
`default_nettype none

package bns_pkg;

  // Notes in each fixed pattern (1 to 8).
  localparam int PATTERN_LEN = 5;
  localparam logic [3:0] PAT_LEN = 4'(PATTERN_LEN);

  // Item function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BEEP  = 2'd1;
  localparam logic [1:0] FUNC_ALERT = 2'd2;
  localparam logic [1:0] FUNC_BOOT  = 2'd3;

  // Active sequence codes; they share encoding with the start functions.
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_BEEP  = 2'd1;
  localparam logic [1:0] SEL_ALERT = 2'd2;
  localparam logic [1:0] SEL_BOOT  = 2'd3;

  // Pattern ROM; entries past the defined notes are silent with zero length.
  localparam logic [15:0] ALERT_FREQ [8] = '{16'd1800, 16'd0, 16'd2400, 16'd0,
                                            16'd3000, 16'd0, 16'd0, 16'd0};
  localparam logic [15:0] ALERT_DUR  [8] = '{16'd70, 16'd40, 16'd90, 16'd40,
                                            16'd110, 16'd0, 16'd0, 16'd0};
  localparam logic [15:0] BOOT_FREQ  [8] = '{16'd880, 16'd0, 16'd1175, 16'd0,
                                            16'd1568, 16'd0, 16'd0, 16'd0};
  localparam logic [15:0] BOOT_DUR   [8] = '{16'd60, 16'd30, 16'd60, 16'd30,
                                            16'd100, 16'd0, 16'd0, 16'd0};

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [15:0] note_freq;
    logic [15:0] note_ms;
  } bns_in_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        seq_active;
    logic [2:0]  note_index;
  } bns_out_t;

endpackage

`default_nettype wire

### hw/rtl/bns_step.sv
// Sequencer state and the per-item update logic.
`default_nettype none

module bns_step
  import bns_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire bns_in_t  item,
  output bns_out_t      result
);

  logic [1:0]  sel_r, sel_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] start_r, start_nxt;
  logic        buzz_r, buzz_nxt;
  logic [15:0] bfreq_r, bfreq_nxt;
  logic [15:0] bdur_r, bdur_nxt;
  logic [15:0] drive_r, drive_nxt;

  logic [3:0]  seq_len;
  logic [15:0] cur_dur;
  logic [31:0] elapsed;
  logic [2:0]  idx_inc;
  logic [15:0] next_freq;
  logic [15:0] first_freq;

  // Duration of the note now playing, frequency of the next note and of a start's first note, and elapsed time.
  always_comb begin
    seq_len = (sel_r == SEL_BEEP) ? 4'd1 : PAT_LEN;
    idx_inc = idx_r + 3'd1;
    elapsed = item.now_ms - start_r;
    unique case (sel_r)
      SEL_BEEP:  cur_dur = bdur_r;
      SEL_ALERT: cur_dur = ALERT_DUR[idx_r];
      SEL_BOOT:  cur_dur = BOOT_DUR[idx_r];
      SEL_NONE:  cur_dur = BOOT_DUR[idx_r];
    endcase
    unique case (sel_r)
      SEL_BEEP:  next_freq = bfreq_r;
      SEL_ALERT: next_freq = ALERT_FREQ[idx_inc];
      SEL_BOOT:  next_freq = BOOT_FREQ[idx_inc];
      SEL_NONE:  next_freq = BOOT_FREQ[idx_inc];
    endcase
    unique case (item.func)
      FUNC_BEEP:  first_freq = item.note_freq;
      FUNC_ALERT: first_freq = ALERT_FREQ[0];
      FUNC_BOOT:  first_freq = BOOT_FREQ[0];
      FUNC_TICK:  first_freq = 16'd0;
    endcase
  end

  // Next state: a tick advances or ends the sequence once the note's time is up, a start loads a new one.
  always_comb begin
    sel_nxt   = sel_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    buzz_nxt  = buzz_r;
    bfreq_nxt = bfreq_r;
    bdur_nxt  = bdur_r;
    drive_nxt = drive_r;
    if (item.func == FUNC_TICK) begin
      if (sel_r == SEL_NONE || {1'b0, idx_r} >= seq_len) begin
        sel_nxt   = SEL_NONE;
        idx_nxt   = 3'd0;
        buzz_nxt  = 1'b0;
        drive_nxt = 16'd0;
      end else if (elapsed >= {16'd0, cur_dur}) begin
        start_nxt = item.now_ms;
        if (idx_inc == 3'd0 || {1'b0, idx_inc} >= seq_len) begin
          sel_nxt   = SEL_NONE;
          idx_nxt   = 3'd0;
          buzz_nxt  = 1'b0;
          drive_nxt = 16'd0;
        end else begin
          idx_nxt   = idx_inc;
          drive_nxt = next_freq;
          buzz_nxt  = (next_freq != 16'd0);
        end
      end
    end else begin
      if (item.func == FUNC_BEEP) begin
        bfreq_nxt = item.note_freq;
        bdur_nxt  = item.note_ms;
      end
      sel_nxt   = item.func;
      idx_nxt   = 3'd0;
      start_nxt = item.now_ms;
      drive_nxt = first_freq;
      buzz_nxt  = (first_freq != 16'd0);
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    result.tone_on    = buzz_nxt;
    result.tone_freq  = drive_nxt;
    result.seq_active = (sel_nxt != SEL_NONE);
    result.note_index = (sel_nxt != SEL_NONE) ? idx_nxt : 3'd0;
  end

  // State registers update once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= SEL_NONE;
      idx_r   <= 3'd0;
      start_r <= 32'd0;
      buzz_r  <= 1'b0;
      bfreq_r <= 16'd0;
      bdur_r  <= 16'd0;
      drive_r <= 16'd0;
    end else if (step_en) begin
      sel_r   <= sel_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      buzz_r  <= buzz_nxt;
      bfreq_r <= bfreq_nxt;
      bdur_r  <= bdur_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/buzzer_note_sequencer.sv
// Top level of the buzzer note sequencer: handshakes, input and result registers.
`default_nettype none

// Buzzer note sequencer. Each accepted item is either a millisecond tick or a
// start command (single beep, alert pattern, boot pattern), and each returns
// exactly one item with the tone state after it. The block takes one item per
// clock cycle unless a held result stalls it. An accepted item waits in the
// input register, and its result is then offered from the result register,
// loaded once that register is free or being taken. The rate is set by the state
// update: a 32-bit elapsed-time subtract and compare plus a small pattern table
// lookup. While out_stall is high the result is held and at most one further
// item is taken into the input register.

module buzzer_note_sequencer
  import bns_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bns_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output bns_out_t      out_item
);

  logic     in_valid_r;
  bns_in_t  in_item_r;
  logic     out_valid_r;
  bns_out_t out_item_r;
  logic     advance;
  logic     step_en;
  bns_out_t step_result;

  // The pipeline moves when the result register is free or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  bns_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .result  (step_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### verif/buzzer_note_sequencer_test.sv
// Self-checking testbench for the buzzer note sequencer with its own note predictor.
`timescale 1ns / 100ps

module buzzer_note_sequencer_test;
  import bns_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bns_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bns_out_t out_item;

  // Items waiting to be offered, and tone states still owed by the block.
  bns_in_t note_items[$];
  bns_out_t tone_expect[$];
  bns_out_t tone_want;

  // Predicted sequencer state.
  logic [1:0] cur_sel = SEL_NONE;
  logic [2:0] cur_step = '0;
  logic [31:0] step_t0 = '0;
  logic buzz_on = 1'b0;
  logic [15:0] beep_hz = '0;
  logic [15:0] beep_len = '0;
  logic [15:0] drive_hz = '0;

  int err_count = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic [31:0] rx_cycle = '0;

  always #10 clk = ~clk;

  buzzer_note_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Frequency and length of note idx in the sequence now selected.
  function automatic logic [15:0] note_hz(logic [2:0] idx);
    case (cur_sel)
      SEL_BEEP:  return beep_hz;
      SEL_ALERT: return ALERT_FREQ[idx];
      default:   return BOOT_FREQ[idx];
    endcase
  endfunction

  function automatic logic [15:0] note_len(logic [2:0] idx);
    case (cur_sel)
      SEL_BEEP:  return beep_len;
      SEL_ALERT: return ALERT_DUR[idx];
      default:   return BOOT_DUR[idx];
    endcase
  endfunction

  function automatic void silence();
    drive_hz = '0;
    buzz_on = 1'b0;
    cur_sel = SEL_NONE;
    cur_step = '0;
  endfunction

  // Applies one item to the predicted state and returns the tone state after it.
  function automatic bns_out_t play_item(bns_in_t it);
    bns_out_t res;
    logic [31:0] elapsed;
    logic [3:0] seq_notes;
    seq_notes = (cur_sel == SEL_BEEP) ? 4'd1 : PAT_LEN;
    if (it.func == FUNC_TICK) begin
      if (cur_sel == SEL_NONE || {1'b0, cur_step} >= seq_notes) begin
        silence();
      end else begin
        elapsed = it.now_ms - step_t0;
        if (elapsed >= {16'd0, note_len(cur_step)}) begin
          cur_step = cur_step + 3'd1;
          step_t0 = it.now_ms;
          if (cur_step == 3'd0 || {1'b0, cur_step} >= seq_notes) begin
            silence();
          end else begin
            drive_hz = note_hz(cur_step);
            buzz_on = (drive_hz != 16'd0);
          end
        end
      end
    end else begin
      // Any start abandons the running sequence and plays note 0 of the new one.
      if (it.func == FUNC_BEEP) begin
        beep_hz = it.note_freq;
        beep_len = it.note_ms;
      end
      cur_sel = it.func;
      cur_step = '0;
      step_t0 = it.now_ms;
      drive_hz = note_hz(3'd0);
      buzz_on = (drive_hz != 16'd0);
    end
    res.tone_on = buzz_on;
    res.tone_freq = drive_hz;
    res.seq_active = (cur_sel != SEL_NONE);
    res.note_index = (cur_sel != SEL_NONE) ? cur_step : 3'd0;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic push_item(logic [1:0] f, logic [31:0] t, logic [15:0] hz, logic [15:0] len);
    bns_in_t it;
    it.func = f;
    it.now_ms = t;
    it.note_freq = hz;
    it.note_ms = len;
    note_items.push_back(it);
  endtask

  // Sender: bursts of items with random gaps; the offered item holds while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tone_expect.push_back(play_item(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (note_items.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= note_items.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that cycles through free, light, heavy and even phases,
  // with long hold-offs that let the block back up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (rx_cycle == 400 || rx_cycle == 2600) begin
        hold_left <= 199;
        out_stall <= 1'b1;
      end else begin
        case (rx_cycle[7:6])
          2'd0:    out_stall <= 1'b0;
          2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
          2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Result checker: every accepted item is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tone_expect.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got %h",
                 $time, out_item);
        err_count++;
      end else begin
        tone_want = tone_expect.pop_front();
        check_field("tone_on", 32'(tone_want.tone_on), 32'(out_item.tone_on));
        check_field("tone_freq", 32'(tone_want.tone_freq), 32'(out_item.tone_freq));
        check_field("seq_active", 32'(tone_want.seq_active), 32'(out_item.seq_active));
        check_field("note_index", 32'(tone_want.note_index), 32'(out_item.note_index));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] t_ms;
    logic [1:0] f;
    logic [15:0] hz;
    logic [15:0] len;
    int pick;
    int n_ticks;

    // Directed: idle tick, extreme beep across the time wrap, silent note,
    // zero length, both patterns with a restart, then a tick after the end.
    push_item(FUNC_TICK, 32'd0, 16'hFFFF, 16'hFFFF);
    push_item(FUNC_BEEP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_item(FUNC_TICK, 32'h0000_FFFD, 16'h0000, 16'h0000);
    push_item(FUNC_TICK, 32'h0000_FFFE, 16'h0000, 16'h0000);
    push_item(FUNC_TICK, 32'h0001_0000, 16'h0000, 16'h0000);
    push_item(FUNC_BEEP, 32'd100, 16'd0, 16'd5);
    push_item(FUNC_TICK, 32'd105, 16'd0, 16'd0);
    push_item(FUNC_BEEP, 32'd200, 16'd440, 16'd0);
    push_item(FUNC_TICK, 32'd200, 16'd0, 16'd0);
    push_item(FUNC_ALERT, 32'd1000, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1069, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1070, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1110, 16'd0, 16'd0);
    push_item(FUNC_BOOT, 32'd1150, 16'hFFFF, 16'hFFFF);
    push_item(FUNC_TICK, 32'd1210, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1240, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1300, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1330, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1430, 16'd0, 16'd0);
    push_item(FUNC_TICK, 32'd1431, 16'd0, 16'd0);
    push_item(FUNC_ALERT, 32'hFFFF_FFC0, 16'hFFFF, 16'hFFFF);
    push_item(FUNC_TICK, 32'h0000_0006, 16'hFFFF, 16'hFFFF);

    // Random: mostly a start followed by advancing ticks, some noise and time jumps.
    t_ms = $urandom;
    while (note_items.size() < RANDOM_ITEMS + 22) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_item(2'($urandom), $urandom, 16'($urandom), 16'($urandom));
      end else begin
        if (pick < 12) t_ms = $urandom;
        f = 2'($urandom_range(1, 3));
        hz = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        case ($urandom_range(0, 9))
          0:       len = 16'd0;
          1, 2:    len = 16'($urandom);
          default: len = 16'($urandom_range(1, 150));
        endcase
        push_item(f, t_ms, hz, len);
        n_ticks = (f == FUNC_BEEP) ? $urandom_range(1, 6) : $urandom_range(2, 20);
        repeat (n_ticks) begin
          // Now and then the clock steps back, which reads as a huge elapsed time.
          if ($urandom_range(0, 19) == 0) t_ms = t_ms - 32'($urandom_range(1, 50));
          else t_ms = t_ms + 32'($urandom_range(0, 60));
          push_item(FUNC_TICK, t_ms, 16'($urandom), 16'($urandom));
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to come back.
    while (note_items.size() != 0 || in_valid || tone_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### buzzer_note_sequencer.f
hw/rtl/bns_pkg.sv
hw/rtl/bns_step.sv
hw/rtl/buzzer_note_sequencer.sv
verif/buzzer_note_sequencer_test.sv
